[src/tst_pkg.sv]
package tst_pkg;

  localparam int KEY_W           = 64;
  localparam int VAL_W           = 16;
  localparam int POS_W           = 4;
  localparam int CAP_W           = 5;
  localparam int IN_DATA_W       = KEY_W + VAL_W;
  localparam int OUT_DATA_W      = 24;
  localparam int DEF_MAX_ENTRIES = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_SWAP_LO,
    ST_SWAP_HI,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    WSEL_INPUT,
    WSEL_LAST,
    WSEL_PREV
  } wsel_e;

  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_PAYLOAD,
    VSEL_LAST
  } vsel_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    logic  cmp_shift;
    logic  wr_en;
    wsel_e wsel;
    logic  out_load;
    logic  out_ok;
    vsel_e vsel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic match;
    logic out_free;
  } status_t;

endpackage

[src/tst_dpath.sv]
module tst_dpath #(
  parameter int MAX_ENTRIES = tst_pkg::DEF_MAX_ENTRIES,
  parameter int IW          = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tst_pkg::cmd_t               cmd_i,
  input  logic [IW-1:0]               rd_addr_i,
  input  logic [IW-1:0]               wr_addr_i,
  input  logic [IW-1:0]               out_pos_i,
  output tst_pkg::status_t            status_o,
  input  logic                        in_mode_i,
  input  logic [tst_pkg::KEY_W-1:0]   in_key_i,
  input  logic [tst_pkg::VAL_W-1:0]   in_payload_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic                        out_ok_o,
  output logic [tst_pkg::VAL_W-1:0]   out_value_o,
  output logic [tst_pkg::POS_W-1:0]   out_pos_o
);
  import tst_pkg::*;

  slot_t mem [MAX_ENTRIES];

  slot_t             rdata_q;
  slot_t             last_q;
  slot_t             prev_q;
  slot_t             wdata;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  payload_q;
  logic              mode_q;

  logic              m_valid_q, m_valid_d;
  logic              ok_q;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [POS_W-1:0]  pos_q;
  logic [IW+POS_W-1:0] pos_ext;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_LAST: wdata = last_q;
      WSEL_PREV: wdata = prev_q;
      default:   wdata = '{key: key_q, value: payload_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= in_key_i;
      payload_q <= in_payload_i;
      mode_q    <= in_mode_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wdata;
    end
    // keep the compared entry and the one before it for the swap
    if (cmd_i.cmp_shift) begin
      last_q <= rdata_q;
      prev_q <= last_q;
    end
  end

  always_comb begin
    case (cmd_i.vsel)
      VSEL_PAYLOAD: value_d = payload_q;
      VSEL_LAST:    value_d = last_q.value;
      default:      value_d = '0;
    endcase
  end

  assign pos_ext = {{POS_W{1'b0}}, out_pos_i};

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ok_q    <= cmd_i.out_ok;
      value_q <= value_d;
      pos_q   <= pos_ext[POS_W-1:0];
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.match    = (rdata_q.key == key_q);
  assign status_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o   = m_valid_q;
  assign out_ok_o    = ok_q;
  assign out_value_o = value_q;
  assign out_pos_o   = pos_q;

endmodule

[src/tst_ctrl.sv]
module tst_ctrl #(
  parameter int MAX_ENTRIES = tst_pkg::DEF_MAX_ENTRIES,
  parameter int IW          = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cfg_we_i,
  input  logic [tst_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  tst_pkg::status_t            status_i,
  output tst_pkg::cmd_t               cmd_o,
  output logic [IW-1:0]               rd_addr_o,
  output logic [IW-1:0]               wr_addr_o,
  output logic [IW-1:0]               out_pos_o
);
  import tst_pkg::*;

  localparam int FW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

  state_e           state_q, state_d;
  logic [FW-1:0]    idx_q, idx_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    fill_m1;
  logic             cmp_v_q, cmp_v_d;
  logic [IW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]    pos_q, pos_d;
  logic             ok_q, ok_d;
  vsel_e            vsel_q, vsel_d;
  logic [CAP_W-1:0] cap_q;

  logic [CMPW-1:0]  cap_ext, eff_cap, fill_ext;
  logic             found, more;

  // a capacity of zero acts as one, anything above the table size as full size
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign fill_ext = CMPW'(fill_q);
  assign fill_m1  = fill_q - FW'(1);
  assign found    = cmp_v_q && status_i.match;
  assign more     = (idx_q < fill_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    cmp_v_d   = cmp_v_q;
    cmp_idx_d = cmp_idx_q;
    pos_d     = pos_q;
    ok_d      = ok_q;
    vsel_d    = vsel_q;

    in_ready_o     = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.cmp_shift = 1'b0;
    cmd_o.wr_en     = 1'b0;
    cmd_o.wsel      = WSEL_INPUT;
    cmd_o.out_load  = 1'b0;
    cmd_o.out_ok    = ok_q;
    cmd_o.vsel      = vsel_q;
    wr_addr_o       = pos_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          cmp_v_d    = 1'b0;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.cmp_shift = cmp_v_q;
        if (found) begin
          cmp_v_d = 1'b0;
          state_d = ST_DONE;
          if (status_i.mode == MODE_LOOKUP) begin
            ok_d   = 1'b1;
            vsel_d = VSEL_LAST;
            if (cmp_idx_q == '0) begin
              pos_d = '0;
            end else begin
              pos_d   = cmp_idx_q - IW'(1);
              state_d = ST_SWAP_LO;
            end
          end else begin
            // duplicate key on insert
            ok_d   = 1'b0;
            vsel_d = VSEL_ZERO;
            pos_d  = '0;
          end
        end else if (more) begin
          cmd_o.rd_en = 1'b1;
          idx_d       = idx_q + FW'(1);
          cmp_v_d     = 1'b1;
          cmp_idx_d   = idx_q[IW-1:0];
        end else begin
          cmp_v_d = 1'b0;
          if (status_i.mode == MODE_INSERT) begin
            ok_d    = 1'b1;
            vsel_d  = VSEL_PAYLOAD;
            state_d = ST_WRITE;
            if (fill_ext < eff_cap) begin
              pos_d  = fill_q[IW-1:0];
              fill_d = fill_q + FW'(1);
            end else begin
              // full: overwrite the last filled slot
              pos_d = fill_m1[IW-1:0];
            end
          end else begin
            ok_d    = 1'b0;
            vsel_d  = VSEL_ZERO;
            pos_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WSEL_INPUT;
        state_d     = ST_DONE;
      end
      ST_SWAP_LO: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WSEL_LAST;
        state_d     = ST_SWAP_HI;
      end
      ST_SWAP_HI: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WSEL_PREV;
        wr_addr_o   = pos_q + IW'(1);
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = idx_q[IW-1:0];
  assign out_pos_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      fill_q    <= '0;
      cmp_v_q   <= 1'b0;
      cmp_idx_q <= '0;
      pos_q     <= '0;
      ok_q      <= 1'b0;
      vsel_q    <= VSEL_ZERO;
      cap_q     <= CAP_RESET;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      fill_q    <= fill_d;
      cmp_v_q   <= cmp_v_d;
      cmp_idx_q <= cmp_idx_d;
      pos_q     <= pos_d;
      ok_q      <= ok_d;
      vsel_q    <= vsel_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[src/transpose_session_table.sv]
// Key/value session table of MAX_ENTRIES slots kept as a self-organizing list.
// An insert item (tuser 0) stores key and payload unless the key is already
// present; once the fill count reaches the capacity register, the last filled
// slot is overwritten. A lookup item (tuser 1) searches from slot 0 and, on a
// hit, swaps the entry with its predecessor; the result carries the value and
// the entry's new slot. The table compares one stored key per cycle through a
// single-port slot memory with registered read, and items are handled one at a
// time. A finished result waits in an output register while the next item is
// accepted. Capacity may be written only while the block is idle; values of 0
// act as 1 and values above MAX_ENTRIES as MAX_ENTRIES.
module transpose_session_table #(
  parameter int MAX_ENTRIES = tst_pkg::DEF_MAX_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tst_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // key[63:0], payload[79:64]
  input  logic                             s_axis_tuser,   // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // value[15:0], position[19:16]
  output logic                             m_axis_tuser,   // ok
  input  logic                             cfg_we_i,
  input  logic [tst_pkg::CAP_W-1:0]        cfg_wdata_i     // capacity
);
  import tst_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    out_pos;
  logic [VAL_W-1:0] out_value;
  logic [POS_W-1:0] out_position;

  tst_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .IW         (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .out_pos_o  (out_pos)
  );

  tst_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .IW         (IW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .out_pos_i   (out_pos),
    .status_o    (status),
    .in_mode_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata[KEY_W-1:0]),
    .in_payload_i(s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_value_o (out_value),
    .out_pos_o   (out_position)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - VAL_W - POS_W){1'b0}}, out_position, out_value};

endmodule
